/* rtl/core/rthf_pkg.sv */
`timescale 1ns / 1ps

package rthf_pkg;

  // Field and intermediate widths.
  localparam int unsigned CoordW   = 32;
  localparam int unsigned EdgeW    = 33;
  localparam int unsigned PvW      = 66;
  localparam int unsigned QvW      = 67;
  localparam int unsigned DotW     = 102;
  localparam int unsigned DistW    = 31;
  localparam int unsigned BaryW    = 17;
  localparam int unsigned IdW      = 32;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  // Determinant threshold, the smallest integer not below 1e-5 in units of 2^-48.
  localparam logic signed [DotW-1:0] DetEps = 102'sd2814749768;
  localparam logic [DistW-1:0] TMax = {DistW{1'b1}};

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_ORIGIN_X = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_ORIGIN_Y = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_ORIGIN_Z = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_DIR_X    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_DIR_Y    = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_DIR_Z    = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_RANGE    = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_MODE     = 3'd7;

  // Sequencer limits.
  localparam logic [4:0] LastOp    = 5'd23;
  localparam logic [5:0] MulMsb    = 6'd32;
  localparam logic [5:0] DivTLast  = 6'd30;
  localparam logic [5:0] DivUvLast = 6'd16;

  typedef struct packed {
    logic signed [CoordW-1:0] v0_x;
    logic signed [CoordW-1:0] v0_y;
    logic signed [CoordW-1:0] v0_z;
    logic signed [CoordW-1:0] v1_x;
    logic signed [CoordW-1:0] v1_y;
    logic signed [CoordW-1:0] v1_z;
    logic signed [CoordW-1:0] v2_x;
    logic signed [CoordW-1:0] v2_y;
    logic signed [CoordW-1:0] v2_z;
    logic [IdW-1:0]           prim_id;
    logic                     new_query;
  } tri_t;

  typedef struct packed {
    logic             reported;
    logic [DistW-1:0] hit_distance;
    logic [BaryW-1:0] bary_u;
    logic [BaryW-1:0] bary_v;
    logic [IdW-1:0]   hit_id;
  } res_t;

  typedef enum logic [1:0] {A_E2, A_S, A_PV, A_QV} a_src_e;
  typedef enum logic [1:0] {B_DIR, B_E1, B_S, B_E2} b_src_e;
  typedef enum logic [2:0] {DST_NONE, DST_PV, DST_QV, DST_DET, DST_UN, DST_VN, DST_TN} dst_e;
  typedef enum logic [1:0] {DIV_T, DIV_U, DIV_V} div_sel_e;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL_LD, S_MUL_RUN, S_CHK_DET, S_NEG, S_CHK_BAR, S_TSAT,
    S_DIV_LD, S_DIV_RUN, S_TTEST, S_FINISH
  } state_e;

  // One multiply-accumulate step of the sequencer program.
  typedef struct packed {
    a_src_e     a_src;
    logic [1:0] a_k;
    b_src_e     b_src;
    logic [1:0] b_k;
    logic       sub;
    logic       first;
    dst_e       dst;
    logic [1:0] d_k;
  } op_t;

  typedef struct packed {
    logic       load;
    logic       op_load;
    logic       mul_bit;
    logic       mul_msb;
    logic [4:0] op_idx;
    logic       neg;
    logic       tsat;
    logic       div_load;
    logic       div_step;
    logic       div_store;
    div_sel_e   div_sel;
    logic       out_load;
    logic       out_hit;
  } cmd_t;

  typedef struct packed {
    logic det_bad;
    logic bar_bad;
    logic t_bad;
  } status_t;

  function automatic op_t mk_op(input a_src_e as, input logic [1:0] ak, input b_src_e bs,
                                input logic [1:0] bk, input logic sb, input logic fs,
                                input dst_e ds, input logic [1:0] dk);
    op_t o;
    o.a_src = as;
    o.a_k   = ak;
    o.b_src = bs;
    o.b_k   = bk;
    o.sub   = sb;
    o.first = fs;
    o.dst   = ds;
    o.d_k   = dk;
    return o;
  endfunction

  // Program: pv = dir x e2, det = e1.pv, qv = s x e1, un = s.pv, vn = dir.qv, tn = e2.qv.
  function automatic op_t op_table(input logic [4:0] idx);
    op_t o;
    case (idx)
      5'd0:    o = mk_op(A_E2, 2'd2, B_DIR, 2'd1, 1'b0, 1'b1, DST_NONE, 2'd0);
      5'd1:    o = mk_op(A_E2, 2'd1, B_DIR, 2'd2, 1'b1, 1'b0, DST_PV,   2'd0);
      5'd2:    o = mk_op(A_E2, 2'd0, B_DIR, 2'd2, 1'b0, 1'b1, DST_NONE, 2'd0);
      5'd3:    o = mk_op(A_E2, 2'd2, B_DIR, 2'd0, 1'b1, 1'b0, DST_PV,   2'd1);
      5'd4:    o = mk_op(A_E2, 2'd1, B_DIR, 2'd0, 1'b0, 1'b1, DST_NONE, 2'd0);
      5'd5:    o = mk_op(A_E2, 2'd0, B_DIR, 2'd1, 1'b1, 1'b0, DST_PV,   2'd2);
      5'd6:    o = mk_op(A_PV, 2'd0, B_E1,  2'd0, 1'b0, 1'b1, DST_NONE, 2'd0);
      5'd7:    o = mk_op(A_PV, 2'd1, B_E1,  2'd1, 1'b0, 1'b0, DST_NONE, 2'd0);
      5'd8:    o = mk_op(A_PV, 2'd2, B_E1,  2'd2, 1'b0, 1'b0, DST_DET,  2'd0);
      5'd9:    o = mk_op(A_S,  2'd1, B_E1,  2'd2, 1'b0, 1'b1, DST_NONE, 2'd0);
      5'd10:   o = mk_op(A_S,  2'd2, B_E1,  2'd1, 1'b1, 1'b0, DST_QV,   2'd0);
      5'd11:   o = mk_op(A_S,  2'd2, B_E1,  2'd0, 1'b0, 1'b1, DST_NONE, 2'd0);
      5'd12:   o = mk_op(A_S,  2'd0, B_E1,  2'd2, 1'b1, 1'b0, DST_QV,   2'd1);
      5'd13:   o = mk_op(A_S,  2'd0, B_E1,  2'd1, 1'b0, 1'b1, DST_NONE, 2'd0);
      5'd14:   o = mk_op(A_S,  2'd1, B_E1,  2'd0, 1'b1, 1'b0, DST_QV,   2'd2);
      5'd15:   o = mk_op(A_PV, 2'd0, B_S,   2'd0, 1'b0, 1'b1, DST_NONE, 2'd0);
      5'd16:   o = mk_op(A_PV, 2'd1, B_S,   2'd1, 1'b0, 1'b0, DST_NONE, 2'd0);
      5'd17:   o = mk_op(A_PV, 2'd2, B_S,   2'd2, 1'b0, 1'b0, DST_UN,   2'd0);
      5'd18:   o = mk_op(A_QV, 2'd0, B_DIR, 2'd0, 1'b0, 1'b1, DST_NONE, 2'd0);
      5'd19:   o = mk_op(A_QV, 2'd1, B_DIR, 2'd1, 1'b0, 1'b0, DST_NONE, 2'd0);
      5'd20:   o = mk_op(A_QV, 2'd2, B_DIR, 2'd2, 1'b0, 1'b0, DST_VN,   2'd0);
      5'd21:   o = mk_op(A_QV, 2'd0, B_E2,  2'd0, 1'b0, 1'b1, DST_NONE, 2'd0);
      5'd22:   o = mk_op(A_QV, 2'd1, B_E2,  2'd1, 1'b0, 1'b0, DST_NONE, 2'd0);
      5'd23:   o = mk_op(A_QV, 2'd2, B_E2,  2'd2, 1'b0, 1'b0, DST_TN,   2'd0);
      default: o = mk_op(A_E2, 2'd0, B_DIR, 2'd0, 1'b0, 1'b1, DST_NONE, 2'd0);
    endcase
    return o;
  endfunction

endpackage

/* rtl/core/rthf_intf.sv */
`timescale 1ns / 1ps

// Triangle word channel.
interface rthf_tri_if;
  logic               valid;
  logic               ready;
  rthf_pkg::tri_t     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// Result word channel.
interface rthf_res_if;
  logic               valid;
  logic               ready;
  rthf_pkg::res_t     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/rthf_ctrl.sv */
`timescale 1ns / 1ps

module rthf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  input  rthf_pkg::status_t status_i,
  output rthf_pkg::cmd_t    cmd_o
);

  rthf_pkg::state_e   state_q, state_d;
  rthf_pkg::div_sel_e dsel_q, dsel_d;
  logic [4:0] op_q, op_d;
  logic [5:0] cnt_q, cnt_d;
  logic       hit_q, hit_d;
  logic       out_valid_q, out_valid_d;
  logic       div_last;

  assign in_ready_o  = (state_q == rthf_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;
  assign div_last    = (dsel_q == rthf_pkg::DIV_T) ? (cnt_q == rthf_pkg::DivTLast)
                                                   : (cnt_q == rthf_pkg::DivUvLast);

  // State and counter registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rthf_pkg::S_IDLE;
      dsel_q      <= rthf_pkg::DIV_T;
      op_q        <= '0;
      cnt_q       <= '0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      dsel_q      <= dsel_d;
      op_q        <= op_d;
      cnt_q       <= cnt_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_d        = state_q;
    dsel_d         = dsel_q;
    op_d           = op_q;
    cnt_d          = cnt_q;
    hit_d          = hit_q;
    cmd_o          = '0;
    cmd_o.op_idx   = op_q;
    cmd_o.div_sel  = dsel_q;
    cmd_o.out_hit  = hit_q;
    cmd_o.mul_msb  = (cnt_q == rthf_pkg::MulMsb);
    case (state_q)
      rthf_pkg::S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          op_d       = '0;
          state_d    = rthf_pkg::S_MUL_LD;
        end
      end
      rthf_pkg::S_MUL_LD: begin
        cmd_o.op_load = 1'b1;
        cnt_d         = '0;
        state_d       = rthf_pkg::S_MUL_RUN;
      end
      rthf_pkg::S_MUL_RUN: begin
        cmd_o.mul_bit = 1'b1;
        cnt_d         = cnt_q + 6'd1;
        if (cnt_q == rthf_pkg::MulMsb) begin
          if (op_q == rthf_pkg::LastOp) begin
            state_d = rthf_pkg::S_CHK_DET;
          end else begin
            op_d    = op_q + 5'd1;
            state_d = rthf_pkg::S_MUL_LD;
          end
        end
      end
      rthf_pkg::S_CHK_DET: begin
        if (status_i.det_bad) begin
          hit_d   = 1'b0;
          state_d = rthf_pkg::S_FINISH;
        end else begin
          state_d = rthf_pkg::S_NEG;
        end
      end
      rthf_pkg::S_NEG: begin
        cmd_o.neg = 1'b1;
        state_d   = rthf_pkg::S_CHK_BAR;
      end
      rthf_pkg::S_CHK_BAR: begin
        if (status_i.bar_bad) begin
          hit_d   = 1'b0;
          state_d = rthf_pkg::S_FINISH;
        end else begin
          state_d = rthf_pkg::S_TSAT;
        end
      end
      rthf_pkg::S_TSAT: begin
        cmd_o.tsat = 1'b1;
        dsel_d     = rthf_pkg::DIV_T;
        state_d    = rthf_pkg::S_DIV_LD;
      end
      rthf_pkg::S_DIV_LD: begin
        cmd_o.div_load = 1'b1;
        cnt_d          = '0;
        state_d        = rthf_pkg::S_DIV_RUN;
      end
      rthf_pkg::S_DIV_RUN: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 6'd1;
        if (div_last) begin
          cmd_o.div_store = 1'b1;
          case (dsel_q)
            rthf_pkg::DIV_T: state_d = rthf_pkg::S_TTEST;
            rthf_pkg::DIV_U: begin
              dsel_d  = rthf_pkg::DIV_V;
              state_d = rthf_pkg::S_DIV_LD;
            end
            default: begin
              hit_d   = 1'b1;
              state_d = rthf_pkg::S_FINISH;
            end
          endcase
        end
      end
      rthf_pkg::S_TTEST: begin
        if (status_i.t_bad) begin
          hit_d   = 1'b0;
          state_d = rthf_pkg::S_FINISH;
        end else begin
          dsel_d  = rthf_pkg::DIV_U;
          state_d = rthf_pkg::S_DIV_LD;
        end
      end
      rthf_pkg::S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = rthf_pkg::S_IDLE;
        end
      end
      default: state_d = rthf_pkg::S_IDLE;
    endcase
  end

  // Output word is held until taken; a new one loads only into a free slot.
  assign out_valid_d = (out_valid_q && !out_ready_i) || cmd_o.out_load;

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over a pending word");
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == rthf_pkg::S_MUL_LD && op_q == 5'd0))
    else $error("accepted word did not start the program");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rthf_pkg::S_MUL_RUN) |-> (cnt_q <= rthf_pkg::MulMsb))
    else $error("multiplier bit count out of range");
  a_op_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_q <= rthf_pkg::LastOp)
    else $error("program index out of range");

endmodule

/* rtl/core/rthf_dp.sv */
`timescale 1ns / 1ps

module rthf_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [rthf_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [rthf_pkg::CfgDataW-1:0]     cfg_data_i,
  input  rthf_pkg::tri_t                    tri_i,
  input  rthf_pkg::cmd_t                    cmd_i,
  output rthf_pkg::status_t                 status_o,
  output rthf_pkg::res_t                    res_o
);

  localparam int unsigned DW = rthf_pkg::DotW;
  localparam int unsigned EW = rthf_pkg::EdgeW;
  localparam int unsigned TW = rthf_pkg::DistW;

  // Configuration registers.
  logic signed [rthf_pkg::CoordW-1:0] org_q [3];
  logic signed [rthf_pkg::CoordW-1:0] dir_q [3];
  logic [TW-1:0] range_q;
  logic [1:0]    mode_q;

  // Per-triangle operands and products.
  logic signed [EW-1:0] e1_q [3];
  logic signed [EW-1:0] e2_q [3];
  logic signed [EW-1:0] s_q  [3];
  logic signed [rthf_pkg::PvW-1:0] pv_q [3];
  logic signed [rthf_pkg::QvW-1:0] qv_q [3];
  logic signed [DW-1:0] det_q, un_q, vn_q, tn_q;
  logic [rthf_pkg::IdW-1:0] id_q;

  // Shift-add multiplier.
  logic signed [DW-1:0] acc_q, ash_q, a_val, addend, acc_nx;
  logic signed [EW-1:0] bsh_q, b_val;
  logic                 neg;
  rthf_pkg::op_t        op;

  // Restoring divider.
  logic [DW-1:0] rem_q, r2, det_u;
  logic [TW-1:0] dsh_q, quo_q, quo_nx;
  logic          ge, sat_q;
  logic [TW-1:0] tq_q, best_q;
  logic [rthf_pkg::BaryW-1:0] uq_q, vq_q;
  logic          found_q;
  rthf_pkg::res_t out_q;

  // Checks.
  logic signed [DW-1:0] det_abs;
  logic signed [DW:0]   uv_sum;
  logic [DW+14:0]       det_sh;

  function automatic logic signed [DW-1:0] pick_a(input logic signed [DW-1:0] x0,
      input logic signed [DW-1:0] x1, input logic signed [DW-1:0] x2, input logic [1:0] k);
    case (k)
      2'd1:    return x1;
      2'd2:    return x2;
      default: return x0;
    endcase
  endfunction

  function automatic logic signed [EW-1:0] pick_b(input logic signed [EW-1:0] x0,
      input logic signed [EW-1:0] x1, input logic signed [EW-1:0] x2, input logic [1:0] k);
    case (k)
      2'd1:    return x1;
      2'd2:    return x2;
      default: return x0;
    endcase
  endfunction

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_q[0] <= '0;
      org_q[1] <= '0;
      org_q[2] <= '0;
      dir_q[0] <= 32'sd65536;
      dir_q[1] <= '0;
      dir_q[2] <= '0;
      range_q  <= rthf_pkg::TMax;
      mode_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rthf_pkg::CFG_ORIGIN_X: org_q[0] <= cfg_data_i;
        rthf_pkg::CFG_ORIGIN_Y: org_q[1] <= cfg_data_i;
        rthf_pkg::CFG_ORIGIN_Z: org_q[2] <= cfg_data_i;
        rthf_pkg::CFG_DIR_X:    dir_q[0] <= cfg_data_i;
        rthf_pkg::CFG_DIR_Y:    dir_q[1] <= cfg_data_i;
        rthf_pkg::CFG_DIR_Z:    dir_q[2] <= cfg_data_i;
        rthf_pkg::CFG_RANGE:    range_q  <= cfg_data_i[TW-1:0];
        rthf_pkg::CFG_MODE:     mode_q   <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // Operand selection for the current program step.
  always_comb begin
    op = rthf_pkg::op_table(cmd_i.op_idx);
    case (op.a_src)
      rthf_pkg::A_E2: a_val = pick_a(DW'(e2_q[0]), DW'(e2_q[1]), DW'(e2_q[2]), op.a_k);
      rthf_pkg::A_S:  a_val = pick_a(DW'(s_q[0]), DW'(s_q[1]), DW'(s_q[2]), op.a_k);
      rthf_pkg::A_PV: a_val = pick_a(DW'(pv_q[0]), DW'(pv_q[1]), DW'(pv_q[2]), op.a_k);
      default:        a_val = pick_a(DW'(qv_q[0]), DW'(qv_q[1]), DW'(qv_q[2]), op.a_k);
    endcase
    case (op.b_src)
      rthf_pkg::B_DIR: b_val = pick_b(EW'(dir_q[0]), EW'(dir_q[1]), EW'(dir_q[2]), op.b_k);
      rthf_pkg::B_E1:  b_val = pick_b(e1_q[0], e1_q[1], e1_q[2], op.b_k);
      rthf_pkg::B_S:   b_val = pick_b(s_q[0], s_q[1], s_q[2], op.b_k);
      default:         b_val = pick_b(e2_q[0], e2_q[1], e2_q[2], op.b_k);
    endcase
  end

  // One multiplier bit per cycle; the sign bit of the multiplier has negative weight.
  assign addend = bsh_q[0] ? ash_q : '0;
  assign neg    = op.sub ^ cmd_i.mul_msb;
  assign acc_nx = neg ? (acc_q - addend) : (acc_q + addend);

  // Edge setup, multiply-accumulate and product storage.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      e1_q[0] <= EW'(tri_i.v1_x) - EW'(tri_i.v0_x);
      e1_q[1] <= EW'(tri_i.v1_y) - EW'(tri_i.v0_y);
      e1_q[2] <= EW'(tri_i.v1_z) - EW'(tri_i.v0_z);
      e2_q[0] <= EW'(tri_i.v2_x) - EW'(tri_i.v0_x);
      e2_q[1] <= EW'(tri_i.v2_y) - EW'(tri_i.v0_y);
      e2_q[2] <= EW'(tri_i.v2_z) - EW'(tri_i.v0_z);
      s_q[0]  <= EW'(org_q[0]) - EW'(tri_i.v0_x);
      s_q[1]  <= EW'(org_q[1]) - EW'(tri_i.v0_y);
      s_q[2]  <= EW'(org_q[2]) - EW'(tri_i.v0_z);
      id_q    <= tri_i.prim_id;
    end
    if (cmd_i.op_load) begin
      ash_q <= a_val;
      bsh_q <= b_val;
      if (op.first) begin
        acc_q <= '0;
      end
    end
    if (cmd_i.mul_bit) begin
      ash_q <= ash_q <<< 1;
      bsh_q <= bsh_q >>> 1;
      acc_q <= acc_nx;
      if (cmd_i.mul_msb) begin
        case (op.dst)
          rthf_pkg::DST_PV: begin
            case (op.d_k)
              2'd1:    pv_q[1] <= acc_nx[rthf_pkg::PvW-1:0];
              2'd2:    pv_q[2] <= acc_nx[rthf_pkg::PvW-1:0];
              default: pv_q[0] <= acc_nx[rthf_pkg::PvW-1:0];
            endcase
          end
          rthf_pkg::DST_QV: begin
            case (op.d_k)
              2'd1:    qv_q[1] <= acc_nx[rthf_pkg::QvW-1:0];
              2'd2:    qv_q[2] <= acc_nx[rthf_pkg::QvW-1:0];
              default: qv_q[0] <= acc_nx[rthf_pkg::QvW-1:0];
            endcase
          end
          rthf_pkg::DST_DET: det_q <= acc_nx;
          rthf_pkg::DST_UN:  un_q  <= acc_nx;
          rthf_pkg::DST_VN:  vn_q  <= acc_nx;
          rthf_pkg::DST_TN:  tn_q  <= acc_nx;
          default: ;
        endcase
      end
    end
    // A negative determinant flips the signs of all four dot products.
    if (cmd_i.neg && det_q[DW-1]) begin
      det_q <= -det_q;
      un_q  <= -un_q;
      vn_q  <= -vn_q;
      tn_q  <= -tn_q;
    end
  end

  // Rejection tests.
  assign det_abs = det_q[DW-1] ? -det_q : det_q;
  assign uv_sum  = (DW+1)'(un_q) + (DW+1)'(vn_q);
  assign det_sh  = {$unsigned(det_q), 15'b0};

  always_comb begin
    status_o.det_bad = mode_q[0] ? (det_q < rthf_pkg::DetEps) : (det_abs < rthf_pkg::DetEps);
    status_o.bar_bad = un_q[DW-1] || (un_q > det_q) || vn_q[DW-1] ||
                       (uv_sum > (DW+1)'(det_q)) || (tn_q <= 0);
    status_o.t_bad   = (tq_q == '0) || (tq_q > best_q) ||
                       (mode_q[1] && found_q && (tq_q >= best_q));
  end

  // Divider step: shift in one dividend bit, subtract when it fits.
  assign det_u  = $unsigned(det_q);
  assign r2     = {rem_q[DW-2:0], dsh_q[TW-1]};
  assign ge     = (r2 >= det_u);
  assign quo_nx = {quo_q[TW-2:0], ge};

  always_ff @(posedge clk_i) begin
    if (cmd_i.tsat) begin
      sat_q <= ({15'b0, $unsigned(tn_q)} >= det_sh);
    end
    if (cmd_i.div_load) begin
      quo_q <= '0;
      case (cmd_i.div_sel)
        rthf_pkg::DIV_T: begin
          rem_q <= {15'b0, tn_q[DW-1:15]};
          dsh_q <= {tn_q[14:0], 16'b0};
        end
        rthf_pkg::DIV_U: begin
          rem_q <= {1'b0, un_q[DW-1:1]};
          dsh_q <= {un_q[0], 30'b0};
        end
        default: begin
          rem_q <= {1'b0, vn_q[DW-1:1]};
          dsh_q <= {vn_q[0], 30'b0};
        end
      endcase
    end
    if (cmd_i.div_step) begin
      rem_q <= ge ? (r2 - det_u) : r2;
      quo_q <= quo_nx;
      dsh_q <= dsh_q << 1;
    end
    if (cmd_i.div_store) begin
      case (cmd_i.div_sel)
        rthf_pkg::DIV_T: tq_q <= sat_q ? rthf_pkg::TMax : quo_nx;
        rthf_pkg::DIV_U: uq_q <= quo_nx[rthf_pkg::BaryW-1:0];
        default:         vq_q <= quo_nx[rthf_pkg::BaryW-1:0];
      endcase
    end
    if (cmd_i.out_load) begin
      if (cmd_i.out_hit) begin
        out_q.reported     <= 1'b1;
        out_q.hit_distance <= tq_q;
        out_q.bary_u       <= uq_q;
        out_q.bary_v       <= vq_q;
        out_q.hit_id       <= id_q;
      end else begin
        out_q <= '0;
      end
    end
  end

  // Query state: current limit and found flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q  <= rthf_pkg::TMax;
      found_q <= 1'b0;
    end else if (cmd_i.load && tri_i.new_query) begin
      best_q  <= range_q;
      found_q <= 1'b0;
    end else if (cmd_i.out_load && cmd_i.out_hit) begin
      found_q <= 1'b1;
      if (mode_q[1]) begin
        best_q <= tq_q;
      end
    end
  end

  assign res_o = out_q;

endmodule

/* rtl/core/ray_triangle_hit_filter.sv */
// Ray / triangle hit filter: one result word per triangle word.
// Throughput: one triangle at a time; the shared 1-bit-per-cycle shift-add multiplier
// (24 products, each loaded and then run bit by bit) and the bit-serial divider set the pace.
// A new triangle is taken while the previous result still waits in the output register.
// Reset (rst_ni low, asynchronous) restores the reset ray, mode, range and limit.
`timescale 1ns / 1ps

module ray_triangle_hit_filter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  rthf_tri_if.sink                      tri_i,
  rthf_res_if.source                    res_o,
  input  logic                          cfg_we_i,
  input  logic [rthf_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [rthf_pkg::CfgDataW-1:0] cfg_data_i
);

  rthf_pkg::cmd_t    cmd;
  rthf_pkg::status_t status;

  // Sequencer.
  rthf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (tri_i.valid),
    .in_ready_o  (tri_i.ready),
    .out_ready_i (res_o.ready),
    .out_valid_o (res_o.valid),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Arithmetic and query state.
  rthf_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .tri_i      (tri_i.data),
    .cmd_i      (cmd),
    .status_o   (status),
    .res_o      (res_o.data)
  );

endmodule
